/* rtl/core/pidc_pkg.sv */
// pidc_pkg: shared widths, register map, reset values and stage types
// for the clamped pid controller. No dependencies.
`default_nettype none

package pidc_pkg;

  // field and datapath widths
  localparam int DataW     = 24;               // Q16.8 samples, Q8.16 gains
  localparam int ErrW      = DataW + 1;        // setpoint - measured, exact
  localparam int IsumW     = DataW + 2;        // integrator + error before clamp
  localparam int DiffW     = ErrW + 1;         // error - last error, exact
  localparam int ProdW     = DataW + DiffW;    // widest gain product
  localparam int AccW      = ProdW + 2;        // sum of three products
  localparam int FracShift = 16;               // Q.24 -> Q16.8
  localparam int ShW       = AccW - FracShift; // shifted sum before saturation

  // configuration port
  localparam int PDataW = 32;
  localparam int AddrW  = 5;

  typedef enum logic [2:0] {
    REG_GAIN_PROP     = 3'd0,
    REG_GAIN_INTEGRAL = 3'd1,
    REG_GAIN_DERIV    = 3'd2,
    REG_LIMIT_HIGH    = 3'd3,
    REG_LIMIT_LOW     = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [DataW-1:0] gain_prop;
    logic [DataW-1:0] gain_integral;
    logic [DataW-1:0] gain_deriv;
    logic [DataW-1:0] limit_high;
    logic [DataW-1:0] limit_low;
  } cfg_t;

  localparam logic signed [DataW-1:0] GainPropReset  = 24'sd15729;
  localparam logic signed [DataW-1:0] LimitHighReset = 24'sd14080;
  localparam logic signed [DataW-1:0] LimitLowReset  = -24'sd14080;

  localparam cfg_t CfgReset = '{
    gain_prop:     GainPropReset,
    gain_integral: '0,
    gain_deriv:    '0,
    limit_high:    LimitHighReset,
    limit_low:     LimitLowReset
  };

  // error stage results
  typedef struct packed {
    logic [ErrW-1:0]  err;
    logic [DataW-1:0] integ;
    logic [DiffW-1:0] diff;
  } upd_t;

  typedef struct packed {
    logic valid;
    upd_t data;
  } upd_req_t;

  // accumulated sum request
  typedef struct packed {
    logic            valid;
    logic [AccW-1:0] acc;
  } acc_req_t;

endpackage

`default_nettype wire

/* rtl/core/pidc_in_if.sv */
// pidc_in_if: sample request channel (setpoint, measured) with valid/ready.
// Depends on pidc_pkg for the field width.
`default_nettype none

interface pidc_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [pidc_pkg::DataW-1:0]  setpoint;
  logic signed [pidc_pkg::DataW-1:0]  measured;

  modport source (output valid, output setpoint, output measured, input ready);
  modport sink   (input valid, input setpoint, input measured, output ready);
endinterface

`default_nettype wire

/* rtl/core/pidc_out_if.sv */
// pidc_out_if: drive result channel with valid/ready.
// Depends on pidc_pkg for the field width.
`default_nettype none

interface pidc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [pidc_pkg::DataW-1:0]  drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

`default_nettype wire

/* rtl/core/pidc_regs.sv */
// pidc_regs: apb-style register file for gains and output limits.
// Depends on pidc_pkg (register map, reset values, cfg_t).
`default_nettype none

module pidc_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pidc_pkg::AddrW-1:0]    paddr,
  input  wire logic [pidc_pkg::PDataW-1:0]   pwdata,
  output logic      [pidc_pkg::PDataW-1:0]   prdata,
  output logic                               pready,
  output pidc_pkg::cfg_t                     cfg
);

  localparam int DataW  = pidc_pkg::DataW;
  localparam int AddrW  = pidc_pkg::AddrW;
  localparam int PDataW = pidc_pkg::PDataW;

  pidc_pkg::cfg_t     cfg_r, cfg_nxt;
  pidc_pkg::reg_idx_t idx;
  logic               wr_en;
  logic [DataW-1:0]   wdata;

  assign idx    = pidc_pkg::reg_idx_t'(paddr[AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign wdata  = pwdata[DataW-1:0];
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        pidc_pkg::REG_GAIN_PROP:     cfg_nxt.gain_prop     = wdata;
        pidc_pkg::REG_GAIN_INTEGRAL: cfg_nxt.gain_integral = wdata;
        pidc_pkg::REG_GAIN_DERIV:    cfg_nxt.gain_deriv    = wdata;
        pidc_pkg::REG_LIMIT_HIGH:    cfg_nxt.limit_high    = wdata;
        pidc_pkg::REG_LIMIT_LOW:     cfg_nxt.limit_low     = wdata;
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= pidc_pkg::CfgReset;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read mux, sign extended to the bus width
  always_comb begin
    unique case (idx)
      pidc_pkg::REG_GAIN_PROP:     prdata = PDataW'($signed(cfg_r.gain_prop));
      pidc_pkg::REG_GAIN_INTEGRAL: prdata = PDataW'($signed(cfg_r.gain_integral));
      pidc_pkg::REG_GAIN_DERIV:    prdata = PDataW'($signed(cfg_r.gain_deriv));
      pidc_pkg::REG_LIMIT_HIGH:    prdata = PDataW'($signed(cfg_r.limit_high));
      pidc_pkg::REG_LIMIT_LOW:     prdata = PDataW'($signed(cfg_r.limit_low));
      default:                     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/pidc_update.sv */
// pidc_update: input register and error stage; forms the error and the error
// difference and updates the clamped integrator. Depends on pidc_pkg, pidc_in_if.
`default_nettype none

module pidc_update (
  input  wire logic        clk,
  input  wire logic        rst_n,
  pidc_in_if.sink          in_ch,
  input  wire pidc_pkg::cfg_t cfg,
  output pidc_pkg::upd_req_t upd,
  input  wire logic        upd_ready
);

  localparam int DataW = pidc_pkg::DataW;
  localparam int ErrW  = pidc_pkg::ErrW;
  localparam int IsumW = pidc_pkg::IsumW;
  localparam int DiffW = pidc_pkg::DiffW;

  logic                     a_valid_r;
  logic signed [DataW-1:0]  sp_r, ms_r;
  logic                     a_ready, a_move, b_ready;
  logic                     b_valid_r;
  pidc_pkg::upd_t           b_data_r, b_data_nxt;

  logic signed [ErrW-1:0]   err, last_err_r;
  logic signed [DataW-1:0]  integ_r, integ_nxt;
  logic signed [DataW-1:0]  int_lo, int_hi;
  logic signed [IsumW-1:0]  isum, ipre;
  logic signed [DiffW-1:0]  diff;

  // stage handshake
  assign b_ready     = !b_valid_r || upd_ready;
  assign a_ready     = !a_valid_r || b_ready;
  assign a_move      = a_valid_r && b_ready;
  assign in_ch.ready = a_ready;

  // error and integrator clamp bounds (floor halving)
  assign err    = ErrW'(sp_r) - ErrW'(ms_r);
  assign int_lo = $signed(cfg.limit_low) >>> 1;
  assign int_hi = $signed(cfg.limit_high) >>> 1;
  assign isum   = IsumW'(integ_r) + IsumW'(err);
  assign ipre   = ($signed(cfg.gain_integral) != 0) ? isum : '0;
  assign diff   = DiffW'(err) - DiffW'(last_err_r);

  // integrator clamp, lower bound tested first
  always_comb begin
    if (ipre < IsumW'(int_lo)) begin
      integ_nxt = int_lo;
    end else if (ipre > IsumW'(int_hi)) begin
      integ_nxt = int_hi;
    end else begin
      integ_nxt = ipre[DataW-1:0];
    end
  end

  always_comb begin
    b_data_nxt.err   = err;
    b_data_nxt.integ = integ_nxt;
    b_data_nxt.diff  = diff;
  end

  // control and loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r  <= 1'b0;
      b_valid_r  <= 1'b0;
      integ_r    <= '0;
      last_err_r <= '0;
    end else begin
      if (a_ready) begin
        a_valid_r <= in_ch.valid;
      end
      if (b_ready) begin
        b_valid_r <= a_valid_r;
      end
      if (a_move) begin
        integ_r    <= integ_nxt;
        last_err_r <= err;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (a_ready && in_ch.valid) begin
      sp_r <= in_ch.setpoint;
      ms_r <= in_ch.measured;
    end
    if (a_move) begin
      b_data_r <= b_data_nxt;
    end
  end

  assign upd.valid = b_valid_r;
  assign upd.data  = b_data_r;

`ifndef SYNTHESIS
  // with integral action and sane limits the integrator lands inside its bounds
  a_int_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (a_move && $signed(cfg.gain_integral) != 0 && int_lo <= int_hi) |=>
    (integ_r >= $past(int_lo) && integ_r <= $past(int_hi)))
    else $error("integrator outside clamp bounds");

  // zero integral gain empties the integrator when zero lies within the bounds
  a_int_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (a_move && $signed(cfg.gain_integral) == 0 && int_lo <= 0 && int_hi >= 0) |=>
    (integ_r == 0))
    else $error("integrator not cleared with zero integral gain");

  // input stalls only when both front stages hold a request
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !a_ready |-> (a_valid_r && b_valid_r))
    else $error("input stalled with a free stage");
`endif

endmodule

`default_nettype wire

/* rtl/core/pidc_mac.sv */
// pidc_mac: gain product stage and product sum stage.
// Depends on pidc_pkg (widths, upd_req_t, acc_req_t, cfg_t).
`default_nettype none

module pidc_mac (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire pidc_pkg::cfg_t     cfg,
  input  wire pidc_pkg::upd_req_t upd,
  output logic               upd_ready,
  output pidc_pkg::acc_req_t acc,
  input  wire logic          acc_ready
);

  localparam int ProdW = pidc_pkg::ProdW;
  localparam int AccW  = pidc_pkg::AccW;

  logic                    c_valid_r, d_valid_r;
  logic                    c_ready, d_ready, c_load, d_load;
  logic signed [ProdW-1:0] p_kp, p_ki, p_kd;
  logic signed [ProdW-1:0] p_kp_r, p_ki_r, p_kd_r;
  logic signed [AccW-1:0]  acc_nxt, acc_r;

  // stage handshake
  assign d_ready   = !d_valid_r || acc_ready;
  assign c_ready   = !c_valid_r || d_ready;
  assign c_load    = upd.valid && c_ready;
  assign d_load    = c_valid_r && d_ready;
  assign upd_ready = c_ready;

  // three independent gain products
  assign p_kp = ProdW'($signed(cfg.gain_prop))     * ProdW'($signed(upd.data.err));
  assign p_ki = ProdW'($signed(cfg.gain_integral)) * ProdW'($signed(upd.data.integ));
  assign p_kd = ProdW'($signed(cfg.gain_deriv))    * ProdW'($signed(upd.data.diff));

  // exact sum of the registered products
  assign acc_nxt = AccW'(p_kp_r) + AccW'(p_ki_r) + AccW'(p_kd_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
    end else begin
      if (c_ready) begin
        c_valid_r <= upd.valid;
      end
      if (d_ready) begin
        d_valid_r <= c_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_load) begin
      p_kp_r <= p_kp;
      p_ki_r <= p_ki;
      p_kd_r <= p_kd;
    end
    if (d_load) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc.valid = d_valid_r;
  assign acc.acc   = acc_r;

endmodule

`default_nettype wire

/* rtl/core/pidc_sat.sv */
// pidc_sat: scales the sum back to Q16.8, saturates to the output limits and
// holds the result register. Depends on pidc_pkg, pidc_out_if.
`default_nettype none

module pidc_sat (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire pidc_pkg::cfg_t     cfg,
  input  wire pidc_pkg::acc_req_t acc,
  output logic               acc_ready,
  pidc_out_if.source         out_ch
);

  localparam int DataW     = pidc_pkg::DataW;
  localparam int ShW       = pidc_pkg::ShW;
  localparam int FracShift = pidc_pkg::FracShift;

  logic                    o_valid_r, load;
  logic signed [ShW-1:0]   sh, lim_lo, lim_hi;
  logic signed [DataW-1:0] drive_nxt, drive_r;

  assign acc_ready = !o_valid_r || out_ch.ready;
  assign load      = acc.valid && acc_ready;

  // floor shift to Q16.8
  assign sh     = ShW'($signed(acc.acc) >>> FracShift);
  assign lim_lo = ShW'($signed(cfg.limit_low));
  assign lim_hi = ShW'($signed(cfg.limit_high));

  // saturation, lower limit tested first
  always_comb begin
    if (sh < lim_lo) begin
      drive_nxt = $signed(cfg.limit_low);
    end else if (sh > lim_hi) begin
      drive_nxt = $signed(cfg.limit_high);
    end else begin
      drive_nxt = sh[DataW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (acc_ready) begin
      o_valid_r <= acc.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      drive_r <= drive_nxt;
    end
  end

  assign out_ch.valid = o_valid_r;
  assign out_ch.drive = drive_r;

`ifndef SYNTHESIS
  // with ordered limits every result lies within them
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    (load && $signed(cfg.limit_low) <= $signed(cfg.limit_high)) |=>
    (drive_r >= $past($signed(cfg.limit_low)) && drive_r <= $past($signed(cfg.limit_high))))
    else $error("drive outside output limits");
`endif

endmodule

`default_nettype wire

/* rtl/core/pid_controller_clamped_top.sv */
// pid_controller_clamped_top: positional pid controller with integrator clamp
// and output saturation. Depends on pidc_pkg, pidc_in_if, pidc_out_if and the
// pidc_regs, pidc_update, pidc_mac and pidc_sat modules.
//
//   channel   direction  handshake          payload
//   in_ch     sink       valid/ready        setpoint, measured (s24 Q16.8)
//   out_ch    source     valid/ready        drive (s24 Q16.8)
//   cfg       slave      apb psel/penable   5 regs at 4*i, 24-bit signed data
//
// one request per cycle sustained while out_ch takes results; an accepted
// request passes in turn through the input, error, product, sum and
// saturation stages, whose register holds the result. The rate is set by the
// integrator/last-error loop, which closes within the error stage.
// reset clears all stage valids, the integrator, the last error and loads
// the default gains and limits; no clearing pass.
// each stage holds while the next one is full; input keeps taking requests
// while any stage is free, also while a result waits on out_ch.
`default_nettype none

module pid_controller_clamped_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  pidc_in_if.sink                           in_ch,
  pidc_out_if.source                        out_ch,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [pidc_pkg::AddrW-1:0]   paddr,
  input  wire logic [pidc_pkg::PDataW-1:0]  pwdata,
  output logic      [pidc_pkg::PDataW-1:0]  prdata,
  output logic                              pready
);

  pidc_pkg::cfg_t     cfg;
  pidc_pkg::upd_req_t upd;
  pidc_pkg::acc_req_t acc;
  logic               upd_ready;
  logic               acc_ready;

  // configuration registers
  pidc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input and error stage
  pidc_update u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .upd       (upd),
    .upd_ready (upd_ready)
  );

  // products and sum
  pidc_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .upd       (upd),
    .upd_ready (upd_ready),
    .acc       (acc),
    .acc_ready (acc_ready)
  );

  // scaling, saturation and result register
  pidc_sat u_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .acc       (acc),
    .acc_ready (acc_ready),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire
